// File: src/hsv_pixel_classifier_with_counts_top_macros.svh
// assertion macros for the checker file
`ifndef HSV_PIXEL_CLASSIFIER_WITH_COUNTS_TOP_MACROS_SVH
`define HSV_PIXEL_CLASSIFIER_WITH_COUNTS_TOP_MACROS_SVH

// property checked only outside reset
`define HSVC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

// property checked at every edge, reset included
`define HSVC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: property failed");

`endif

// File: src/hsvc_pkg.sv
package hsvc_pkg;

  localparam int COUNT_W = 16;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_PURPLE_AS_WALL = 1'b0,
    CFG_DARK_LIMIT     = 1'b1
  } cfg_index_t;

  localparam logic       PURPLE_AS_WALL_RST = 1'b1;
  localparam logic [7:0] DARK_LIMIT_RST     = 8'd70;

  // strong color gate, shared by red, green, purple
  localparam logic [7:0] STRONG_SAT_MIN = 8'd120;
  localparam logic [7:0] STRONG_VAL_LO  = 8'd60;
  localparam logic [7:0] STRONG_VAL_HI  = 8'd240;

  // hue windows
  localparam logic [7:0] RED_HUE_LO     = 8'd15;
  localparam logic [7:0] RED_HUE_HI     = 8'd175;
  localparam logic [7:0] GREEN_HUE_LO   = 8'd45;
  localparam logic [7:0] GREEN_HUE_HI   = 8'd90;
  localparam logic [7:0] PURPLE_HUE_LO  = 8'd135;
  localparam logic [7:0] PURPLE_HUE_HI  = 8'd175;
  localparam logic [7:0] BLUE_HUE_LO    = 8'd90;
  localparam logic [7:0] BLUE_HUE_HI    = 8'd135;
  localparam logic [7:0] ORANGE_HUE_LO  = 8'd15;
  localparam logic [7:0] ORANGE_HUE_HI  = 8'd45;

  // blue gate
  localparam logic [7:0] BLUE_SAT_MIN   = 8'd60;
  localparam logic [7:0] BLUE_VAL_LO    = 8'd70;
  localparam logic [7:0] BLUE_VAL_HI    = 8'd200;

  // orange gate
  localparam logic [7:0] ORANGE_SAT_MIN = 8'd30;
  localparam logic [7:0] ORANGE_VAL_LO  = 8'd60;
  localparam logic [7:0] ORANGE_VAL_HI  = 8'd240;

  // per-pixel class flags
  typedef struct packed {
    logic red;
    logic green;
    logic purple;
    logic blue;
    logic orange;
    logic wall;
  } pixel_class_t;

endpackage

// File: src/hsvc_classify.sv
module hsvc_classify (
  input  logic [7:0]            hue,
  input  logic [7:0]            saturation,
  input  logic [7:0]            brightness,
  input  logic                  purple_as_wall,
  input  logic [7:0]            dark_limit,
  output hsvc_pkg::pixel_class_t cls
);
  import hsvc_pkg::*;

  logic vivid;
  logic dark;

  // shared gate for the strong colors
  assign vivid = (saturation > STRONG_SAT_MIN) && (brightness > STRONG_VAL_LO)
                 && (brightness < STRONG_VAL_HI);

  // hue windows
  assign cls.red    = vivid && ((hue < RED_HUE_LO) || (hue > RED_HUE_HI));
  assign cls.green  = vivid && (hue > GREEN_HUE_LO) && (hue < GREEN_HUE_HI);
  assign cls.purple = vivid && (hue >= PURPLE_HUE_LO) && (hue <= PURPLE_HUE_HI);
  assign cls.blue   = (saturation > BLUE_SAT_MIN) && (brightness > BLUE_VAL_LO)
                      && (brightness < BLUE_VAL_HI)
                      && (hue > BLUE_HUE_LO) && (hue < BLUE_HUE_HI);
  assign cls.orange = (saturation > ORANGE_SAT_MIN) && (brightness > ORANGE_VAL_LO)
                      && (brightness < ORANGE_VAL_HI)
                      && (hue >= ORANGE_HUE_LO) && (hue <= ORANGE_HUE_HI);

  // wall: dark pixel, or bright purple when enabled
  assign dark     = brightness < dark_limit;
  assign cls.wall = dark || (cls.purple && purple_as_wall);

endmodule

// File: src/hsv_pixel_classifier_with_counts_top.sv
// HSV pixel classifier with per-frame counts.
// Input channel (in_valid/in_ready) takes one HSV pixel per request in raster
// order, with last_pixel set on the final pixel of a frame. Output channel
// (out_valid/out_ready) returns one result per pixel: red, green and purple
// hits for that pixel plus blue, orange, left-wall and right-wall totals of
// the frame so far, this pixel included. frame_done marks the final totals;
// all counters and the column counter clear after that pixel.
// A pixel passes two registers: an input register, then the classifier and
// counter update feeding the result register. Throughput is one pixel per cycle
// while out_ready holds, set by the single classify/increment pass between them.
// When the receiver stalls the result register holds, the input register
// fills, and in_ready drops; nothing is lost. The column counter wraps at
// IMAGE_WIDTH; columns below IMAGE_WIDTH/2 count as left.
// Counts saturate at 65535. Synchronous active-high reset clears the
// counters, the pipeline valids and loads purple_as_wall = 1, dark_limit = 70.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once; the user
// must make them while the block is idle, which the block does not enforce.
module hsv_pixel_classifier_with_counts_top #(
  parameter int IMAGE_WIDTH = 320
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  hsvc_pkg::cfg_index_t         cfg_index,
  input  logic [7:0]                   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   hue,
  input  logic [7:0]                   saturation,
  input  logic [7:0]                   brightness,
  input  logic                         last_pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         red_hit,
  output logic                         green_hit,
  output logic                         purple_hit,
  output logic [hsvc_pkg::COUNT_W-1:0] blue_total,
  output logic [hsvc_pkg::COUNT_W-1:0] orange_total,
  output logic [hsvc_pkg::COUNT_W-1:0] left_wall_total,
  output logic [hsvc_pkg::COUNT_W-1:0] right_wall_total,
  output logic                         frame_done
);
  import hsvc_pkg::*;

  localparam int COL_W = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [COL_W-1:0] COL_HALF = COL_W'(IMAGE_WIDTH / 2);

  // configuration registers
  logic       purple_as_wall;
  logic [7:0] dark_limit;

  // input register
  logic       in_reg_valid;
  logic [7:0] hue_q;
  logic [7:0] sat_q;
  logic [7:0] val_q;
  logic       last_q;

  // frame state
  logic [COL_W-1:0]   column_pos;
  logic [COUNT_W-1:0] blue_acc;
  logic [COUNT_W-1:0] orange_acc;
  logic [COUNT_W-1:0] left_acc;
  logic [COUNT_W-1:0] right_acc;

  logic [COL_W-1:0]   column_pos_next;
  logic [COUNT_W-1:0] blue_acc_next;
  logic [COUNT_W-1:0] orange_acc_next;
  logic [COUNT_W-1:0] left_acc_next;
  logic [COUNT_W-1:0] right_acc_next;

  pixel_class_t cls;
  logic         out_free;
  logic         advance;
  logic         is_left;

  // handshake: result register frees when empty or taken
  assign out_free = !out_valid || out_ready;
  assign advance  = in_reg_valid && out_free;
  assign in_ready = !in_reg_valid || out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      purple_as_wall <= PURPLE_AS_WALL_RST;
      dark_limit     <= DARK_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PURPLE_AS_WALL: purple_as_wall <= cfg_data[0];
        CFG_DARK_LIMIT:     dark_limit     <= cfg_data;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hue_q  <= hue;
      sat_q  <= saturation;
      val_q  <= brightness;
      last_q <= last_pixel;
    end
  end

  hsvc_classify u_classify (
    .hue            (hue_q),
    .saturation     (sat_q),
    .brightness     (val_q),
    .purple_as_wall (purple_as_wall),
    .dark_limit     (dark_limit),
    .cls            (cls)
  );

  // saturating counter updates and column tracking
  assign is_left = column_pos < COL_HALF;

  always_comb begin
    blue_acc_next   = blue_acc;
    orange_acc_next = orange_acc;
    left_acc_next   = left_acc;
    right_acc_next  = right_acc;
    if (cls.blue && (blue_acc != '1)) begin
      blue_acc_next = blue_acc + 1'b1;
    end
    if (cls.orange && (orange_acc != '1)) begin
      orange_acc_next = orange_acc + 1'b1;
    end
    if (cls.wall && is_left && (left_acc != '1)) begin
      left_acc_next = left_acc + 1'b1;
    end
    if (cls.wall && !is_left && (right_acc != '1)) begin
      right_acc_next = right_acc + 1'b1;
    end
    if (last_q || (column_pos == COL_LAST)) begin
      column_pos_next = '0;
    end else begin
      column_pos_next = column_pos + 1'b1;
    end
  end

  // frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      blue_acc   <= '0;
      orange_acc <= '0;
      left_acc   <= '0;
      right_acc  <= '0;
    end else if (advance) begin
      column_pos <= column_pos_next;
      if (last_q) begin
        blue_acc   <= '0;
        orange_acc <= '0;
        left_acc   <= '0;
        right_acc  <= '0;
      end else begin
        blue_acc   <= blue_acc_next;
        orange_acc <= orange_acc_next;
        left_acc   <= left_acc_next;
        right_acc  <= right_acc_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red_hit          <= cls.red;
      green_hit        <= cls.green;
      purple_hit       <= cls.purple;
      blue_total       <= blue_acc_next;
      orange_total     <= orange_acc_next;
      left_wall_total  <= left_acc_next;
      right_wall_total <= right_acc_next;
      frame_done       <= last_q;
    end
  end

endmodule

// File: src/hsvc_checker.sv
`include "hsv_pixel_classifier_with_counts_top_macros.svh"

module hsvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] blue_total,
  input logic [15:0] left_wall_total,
  input logic        frame_done
);

  // no result right after reset
  `HSVC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // stalled result holds
  `HSVC_ASSERT(a_stall_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(blue_total) && $stable(left_wall_total) && $stable(frame_done))

  // an empty result register never blocks input
  `HSVC_ASSERT(a_empty_ready, clk, rst, !out_valid |-> in_ready)

  // an accepted pixel reaches the result register through the input register
  `HSVC_ASSERT(a_latency, clk, rst, in_valid && in_ready |-> ##2 out_valid)

endmodule

bind hsv_pixel_classifier_with_counts_top hsvc_checker u_hsvc_checker (.*);
